FILE: design/flashlight_mode_controller_unit_assert.svh
`ifndef FLASHLIGHT_MODE_CONTROLLER_UNIT_ASSERT_SVH
`define FLASHLIGHT_MODE_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/fmc_pkg.sv
package fmc_pkg;

    // Event kinds
    localparam logic [1:0] KIND_POWER_ON = 2'd0;
    localparam logic [1:0] KIND_TICK     = 2'd1;
    localparam logic [1:0] KIND_SAMPLE   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_MOON_PRESENT   = 3'd0;
    localparam logic [2:0] CFG_HIGH_TO_LOW    = 3'd1;
    localparam logic [2:0] CFG_MEMORY_ON      = 3'd2;
    localparam logic [2:0] CFG_LOW_THRESHOLD  = 3'd3;
    localparam logic [2:0] CFG_CRIT_THRESHOLD = 3'd4;
    localparam logic [2:0] CFG_TURBO_TICKS    = 3'd5;
    localparam logic [2:0] CFG_SAVE_TICKS     = 3'd6;

    localparam logic [7:0] LEVEL_MOON    = 8'd3;
    localparam logic [7:0] LEVEL_LOW     = 8'd14;
    localparam logic [7:0] LEVEL_MID     = 8'd39;
    localparam logic [7:0] LEVEL_HIGH    = 8'd110;
    localparam logic [7:0] LEVEL_TURBO   = 8'd255;
    localparam logic [3:0] LOW_RUN_LIMIT = 4'd8;
    localparam logic [7:0] NO_RECORD     = 8'd255;
    localparam logic [4:0] FLAG_SHORT    = 5'h10;
    localparam logic [7:0] TICK_MAX      = 8'd255;

    localparam logic [3:0] FLASH_NONE     = 4'd0;
    localparam logic [3:0] FLASH_STEPDOWN = 4'd3;
    localparam logic [3:0] FLASH_SHUTDOWN = 4'd10;

    typedef struct packed {
        logic [3:0] count;
        logic       hit;
    } t_low_run;

    // Duty level of a mode index; indexes past the table read as turbo.
    function automatic logic [7:0] level_of(input logic [2:0] idx, input logic moon);
        logic [2:0] eff;
        logic [7:0] lvl;
        eff = moon ? idx - 3'd1 : idx;
        case (eff)
            3'd0:    lvl = LEVEL_LOW;
            3'd1:    lvl = LEVEL_MID;
            3'd2:    lvl = LEVEL_HIGH;
            default: lvl = LEVEL_TURBO;
        endcase
        if (moon && idx == 3'd0) begin
            lvl = LEVEL_MOON;
        end
        return lvl;
    endfunction

endpackage

FILE: design/fmc_in_if.sv
interface fmc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] stored_record;
    logic [7:0] adc_value;

    modport source (output valid, kind, stored_record, adc_value, input ready);
    modport sink (input valid, kind, stored_record, adc_value, output ready);
endinterface

FILE: design/fmc_out_if.sv
interface fmc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] level;
    logic       store_valid;
    logic [4:0] store_value;
    logic [3:0] flash_count;
    logic       powered_off;

    modport source (output valid, level, store_valid, store_value, flash_count,
                    powered_off, input ready);
    modport sink (input valid, level, store_valid, store_value, flash_count,
                  powered_off, output ready);
endinterface

FILE: design/fmc_low_run.sv
module fmc_low_run (
    input  logic              [3:0] i_count,
    input  logic              [7:0] i_adc,
    input  logic              [7:0] i_threshold,
    output fmc_pkg::t_low_run       o_run
);
    logic [3:0] count_inc;

    assign count_inc = i_count + 4'd1;

    always_comb begin
        o_run.count = '0;
        o_run.hit   = 1'b0;
        if (i_adc < i_threshold) begin
            // ninth low sample in a row fires and restarts the run
            if (count_inc > fmc_pkg::LOW_RUN_LIMIT) begin
                o_run.hit = 1'b1;
            end else begin
                o_run.count = count_inc;
            end
        end
    end
endmodule

FILE: design/flashlight_mode_controller_unit.sv
// Pipeline: input register, then result register; a stalled result holds the request
// in the input register. Throughput: one request per cycle while the result is not
// stalled. A stalled result blocks new requests only once the input register is also
// full; input ready follows result ready combinationally.
// Reset (i_rst_n low, synchronous): light waits for power-on, all counters zero,
// configuration back to its defaults, both pipeline registers empty.
module flashlight_mode_controller_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic       [2:0] i_cfg_index,
    input  logic       [7:0] i_cfg_data,
    fmc_in_if.sink           i_req,
    fmc_out_if.source        o_rsp
);
    typedef enum logic [1:0] {
        PH_WAIT_ON,
        PH_RUN,
        PH_WAIT_CRIT,
        PH_OFF
    } t_phase;

    // configuration
    logic       r_moon_present, r_high_to_low, r_memory_on;
    logic [7:0] r_low_threshold, r_crit_threshold, r_turbo_ticks, r_save_ticks;

    // state
    t_phase     r_phase, n_phase;
    logic [2:0] r_mode, n_mode;
    logic [7:0] r_drive, n_drive;
    logic [7:0] r_tick, n_tick;
    logic [3:0] r_low, n_low;

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_kind;
    logic [7:0] r_in_rec;
    logic [7:0] r_in_adc;

    // result register
    logic       r_out_valid;
    logic       r_store_valid, n_store_valid;
    logic [4:0] r_store_value, n_store_value;
    logic [3:0] r_flash, n_flash;

    logic       advance;
    logic [2:0] top;
    logic [7:0] floor_level;
    logic [3:0] rec_idx;
    logic [2:0] clamped;
    logic [2:0] stepped;
    logic [7:0] tick_inc;
    logic [7:0] half;
    logic [2:0] mode_a;
    logic [7:0] drive_a;
    logic [7:0] run_threshold;
    fmc_pkg::t_low_run low_run;

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;

    assign top         = r_moon_present ? 3'd4 : 3'd3;
    assign floor_level = fmc_pkg::level_of(3'd0, r_moon_present);

    assign run_threshold = (r_phase == PH_WAIT_CRIT) ? r_crit_threshold : r_low_threshold;

    fmc_low_run u_low_run (
        .i_count     (r_low),
        .i_adc       (r_in_adc),
        .i_threshold (run_threshold),
        .o_run       (low_run)
    );

    always_comb begin
        rec_idx = r_in_rec[3:0];
        clamped = (rec_idx > {1'b0, top}) ? top : rec_idx[2:0];
        if (r_high_to_low) begin
            stepped = (clamped == 3'd0) ? top : clamped - 3'd1;
        end else begin
            stepped = (clamped >= top) ? 3'd0 : clamped + 3'd1;
        end
        tick_inc = (r_tick == fmc_pkg::TICK_MAX) ? r_tick : r_tick + 8'd1;

        half    = {1'b0, r_drive[7:1]};
        mode_a  = (half < floor_level) ? 3'd0 : r_mode;
        drive_a = (half < floor_level) ? floor_level : half;
        if (mode_a != 3'd0 && drive_a < fmc_pkg::level_of(mode_a, r_moon_present)) begin
            mode_a = mode_a - 3'd1;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_mode        = r_mode;
        n_drive       = r_drive;
        n_tick        = r_tick;
        n_low         = r_low;
        n_store_valid = 1'b0;
        n_store_value = '0;
        n_flash       = fmc_pkg::FLASH_NONE;
        unique case (r_in_kind)
            fmc_pkg::KIND_POWER_ON: begin
                if (r_in_rec == fmc_pkg::NO_RECORD) begin
                    n_mode = 3'd0;
                end else begin
                    n_mode = r_in_rec[4] ? stepped : clamped;
                end
                n_drive       = fmc_pkg::level_of(n_mode, r_moon_present);
                n_tick        = '0;
                n_low         = '0;
                n_phase       = PH_RUN;
                n_store_valid = 1'b1;
                n_store_value = {2'b00, n_mode} | fmc_pkg::FLAG_SHORT;
            end
            fmc_pkg::KIND_TICK: begin
                if (r_phase == PH_RUN || r_phase == PH_WAIT_CRIT) begin
                    n_tick = tick_inc;
                    if (tick_inc == r_save_ticks) begin
                        n_store_valid = 1'b1;
                        if (r_memory_on) begin
                            n_store_value = {2'b00, r_mode};
                        end else begin
                            n_store_value = r_high_to_low ? {2'b00, top} : 5'd0;
                        end
                    end else if (tick_inc == r_turbo_ticks && r_mode == top) begin
                        // turbo timeout drops one mode
                        n_mode  = r_mode - 3'd1;
                        n_drive = fmc_pkg::level_of(n_mode, r_moon_present);
                    end
                end
            end
            fmc_pkg::KIND_SAMPLE: begin
                if (r_phase == PH_RUN) begin
                    n_low = low_run.count;
                    if (low_run.hit) begin
                        if (r_mode == 3'd0 && r_drive <= floor_level) begin
                            n_phase = PH_WAIT_CRIT;
                        end else begin
                            n_flash = fmc_pkg::FLASH_STEPDOWN;
                            n_mode  = mode_a;
                            n_drive = drive_a;
                        end
                    end
                end else if (r_phase == PH_WAIT_CRIT) begin
                    n_low = low_run.count;
                    if (low_run.hit) begin
                        n_flash = fmc_pkg::FLASH_SHUTDOWN;
                        n_drive = '0;
                        n_phase = PH_OFF;
                    end
                end
            end
            default: begin
                // unused kind: report status only
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moon_present   <= 1'b0;
            r_high_to_low    <= 1'b0;
            r_memory_on      <= 1'b1;
            r_low_threshold  <= 8'd130;
            r_crit_threshold <= 8'd120;
            r_turbo_ticks    <= 8'd240;
            r_save_ticks     <= 8'd2;
            r_phase          <= PH_WAIT_ON;
            r_mode           <= '0;
            r_drive          <= '0;
            r_tick           <= '0;
            r_low            <= '0;
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_store_valid    <= 1'b0;
            r_store_value    <= '0;
            r_flash          <= fmc_pkg::FLASH_NONE;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    fmc_pkg::CFG_MOON_PRESENT:   r_moon_present   <= i_cfg_data[0];
                    fmc_pkg::CFG_HIGH_TO_LOW:    r_high_to_low    <= i_cfg_data[0];
                    fmc_pkg::CFG_MEMORY_ON:      r_memory_on      <= i_cfg_data[0];
                    fmc_pkg::CFG_LOW_THRESHOLD:  r_low_threshold  <= i_cfg_data;
                    fmc_pkg::CFG_CRIT_THRESHOLD: r_crit_threshold <= i_cfg_data;
                    fmc_pkg::CFG_TURBO_TICKS:    r_turbo_ticks    <= i_cfg_data;
                    fmc_pkg::CFG_SAVE_TICKS:     r_save_ticks     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_phase       <= n_phase;
                r_mode        <= n_mode;
                r_drive       <= n_drive;
                r_tick        <= n_tick;
                r_low         <= n_low;
                r_out_valid   <= 1'b1;
                r_store_valid <= n_store_valid;
                r_store_value <= n_store_value;
                r_flash       <= n_flash;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_kind <= i_req.kind;
            r_in_rec  <= i_req.stored_record;
            r_in_adc  <= i_req.adc_value;
        end
    end

    // level and power state come straight from the state registers, which
    // update together with the result register
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.level       = r_drive;
    assign o_rsp.store_valid = r_store_valid;
    assign o_rsp.store_value = r_store_value;
    assign o_rsp.flash_count = r_flash;
    assign o_rsp.powered_off = (r_phase == PH_OFF);
endmodule

FILE: design/fmc_checker.sv
`include "flashlight_mode_controller_unit_assert.svh"

module fmc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_level,
    input logic       i_store_valid,
    input logic [4:0] i_store_value,
    input logic [3:0] i_flash_count,
    input logic       i_powered_off
);
    logic stalled;
    logic store_idle;
    logic off_shown;
    logic shutdown;
    logic flash_known;

    assign stalled     = i_out_valid && !i_out_ready;
    assign store_idle  = i_out_valid && !i_store_valid;
    assign off_shown   = i_out_valid && i_powered_off;
    assign shutdown    = i_out_valid && (i_flash_count == fmc_pkg::FLASH_SHUTDOWN);
    assign flash_known = (i_flash_count == fmc_pkg::FLASH_NONE) ||
                         (i_flash_count == fmc_pkg::FLASH_STEPDOWN) ||
                         (i_flash_count == fmc_pkg::FLASH_SHUTDOWN);

    `FMC_ASSERT_NEXT(a_out_hold, stalled, i_out_valid, "result request dropped while stalled")
    `FMC_ASSERT_NOW(a_store_idle, store_idle, i_store_value == 5'd0, "stray store value")
    `FMC_ASSERT_NOW(a_off_dark, off_shown, i_level == 8'd0, "light driven after shutdown")
    `FMC_ASSERT_NOW(a_shutdown_off, shutdown, i_powered_off, "shutdown flashes while on")
    `FMC_ASSERT_NOW(a_flash_code, i_out_valid, flash_known, "unexpected flash count")
endmodule

bind flashlight_mode_controller_unit fmc_checker u_fmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_level       (o_rsp.level),
    .i_store_valid (o_rsp.store_valid),
    .i_store_value (o_rsp.store_value),
    .i_flash_count (o_rsp.flash_count),
    .i_powered_off (o_rsp.powered_off)
);
